FILE: sv/tsm_pkg.sv
// Types and constants shared by the three-stack store.
// Depends on nothing; every other file imports it.
package tsm_pkg;

	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;

	localparam word_t MOST_NEG = {1'b1, {(WORD_W-1){1'b0}}};

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	localparam logic [1:0] SEL_NONE   = 2'd0;
	localparam logic [1:0] SEL_BOTTOM = 2'd1;
	localparam logic [1:0] SEL_TOP    = 2'd2;
	localparam logic [1:0] SEL_MIDDLE = 2'd3;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// What a storage cell does at the next clock edge.
	typedef enum logic [1:0] {
		OP_HOLD  = 2'd0,
		OP_LOAD  = 2'd1,
		OP_LEFT  = 2'd2,
		OP_RIGHT = 2'd3
	} cell_op_t;

endpackage

FILE: sv/tsm_if.sv
// Request and result channel interfaces of the three-stack store.
// Depends on tsm_pkg.
interface tsm_req_if import tsm_pkg::*;;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [1:0] stack_select;
	word_t      push_value;

	modport source (output valid, mode, stack_select, push_value, input ready);
	modport sink   (input valid, mode, stack_select, push_value, output ready);
endinterface

interface tsm_rsp_if import tsm_pkg::*;;
	logic    valid;
	logic    ready;
	word_t   pop_value;
	status_t status;

	modport source (output valid, pop_value, status, input ready);
	modport sink   (input valid, pop_value, status, output ready);
endinterface

FILE: sv/tsm_cell.sv
// One word cell of the shared store: holds, loads, or takes a neighbour's word.
// Depends on tsm_pkg.
module tsm_cell import tsm_pkg::*; (
	input  logic     clk,
	input  cell_op_t op,
	input  word_t    load_word,
	input  word_t    left_word,
	input  word_t    right_word,
	output word_t    word
);

	word_t word_q;

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD:  word_q <= load_word;
			OP_LEFT:  word_q <= left_word;
			OP_RIGHT: word_q <= right_word;
			default:  word_q <= word_q;
		endcase
	end

	assign word = word_q;

endmodule

FILE: sv/three_stacks_shared_memory_core.sv
// Top level of the three-stack store: pointer control, cell row, read select, result register.
// Depends on tsm_pkg, tsm_if and tsm_cell.
//
//  channel | direction | payload                              | handshake
//  --------+-----------+--------------------------------------+-------------
//  req     | in        | mode, stack_select, push_value       | valid/ready
//  rsp     | out       | pop_value, status                    | valid/ready
//
// Each request is taken at a clock edge that also writes its result into the result register,
// so one request per cycle is sustained while the result side keeps up.
// The figure is set by the cell row: a slide of the middle stack is one shift of the
// cells, done in the same edge as the push that needs it.
// A new request is taken whenever the result register is empty or being emptied.
// Reset sets the stack pointers and clears the result valid flag; the cells hold no defined value until written.
module three_stacks_shared_memory_core import tsm_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	tsm_req_if.sink   req,
	tsm_rsp_if.source rsp
);

	// Pointers are kept as counts: bottom count, middle base, middle top plus one, upper top.
	localparam int PW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PW-1:0] MID_RESET = PW'((DEPTH - 1) / 3 + 1);
	localparam logic [PW-1:0] TOP_RESET = PW'(DEPTH);

	logic [PW-1:0] bt1_q, mb_q, mt1_q, ut_q;
	logic [PW-1:0] bt1_d, mb_d, mt1_d, ut_d;

	logic          accept;
	logic          full;
	logic          slide_up, slide_down, wr_en;
	logic [PW-1:0] waddr;
	logic [PW-1:0] raddr;
	status_t       st;
	logic          take_read;

	word_t    cell_word [DEPTH];
	cell_op_t cell_op   [DEPTH];

	logic    out_valid_q;
	word_t   pop_value_q;
	status_t status_q;

	assign accept    = req.valid && req.ready;
	assign req.ready = !out_valid_q || rsp.ready;
	assign full      = (bt1_q == mb_q) && (mt1_q == ut_q);

	// Decode of the request against the current pointers.
	always_comb begin
		bt1_d      = bt1_q;
		mb_d       = mb_q;
		mt1_d      = mt1_q;
		ut_d       = ut_q;
		slide_up   = 1'b0;
		slide_down = 1'b0;
		wr_en      = 1'b0;
		waddr      = '0;
		raddr      = '0;
		take_read  = 1'b0;
		st         = ST_OK;
		if (req.stack_select != SEL_NONE) begin
			if (req.mode == MODE_PUSH) begin
				if (full) begin
					st = ST_OVERFLOW;
				end else begin
					wr_en = 1'b1;
					case (req.stack_select)
						SEL_BOTTOM: begin
							// Middle stack sits right above: shift it up one place.
							slide_up = (bt1_q == mb_q);
							waddr    = bt1_q;
							bt1_d    = bt1_q + 1'b1;
							if (slide_up) begin
								mb_d  = mb_q + 1'b1;
								mt1_d = mt1_q + 1'b1;
							end
						end
						SEL_TOP: begin
							slide_down = (ut_q == mt1_q);
							waddr      = ut_q - 1'b1;
							ut_d       = ut_q - 1'b1;
							if (slide_down) begin
								mb_d  = mb_q - 1'b1;
								mt1_d = mt1_q - 1'b1;
							end
						end
						default: begin
							// Middle push that meets the top stack moves the middle down first.
							slide_down = (mt1_q == ut_q);
							if (slide_down) begin
								mb_d  = mb_q - 1'b1;
								waddr = mt1_q - 1'b1;
							end else begin
								waddr = mt1_q;
								mt1_d = mt1_q + 1'b1;
							end
						end
					endcase
				end
			end else begin
				case (req.stack_select)
					SEL_BOTTOM: begin
						if (bt1_q == '0) begin
							st = ST_UNDERFLOW;
						end else begin
							take_read = 1'b1;
							raddr     = bt1_q - 1'b1;
							bt1_d     = bt1_q - 1'b1;
						end
					end
					SEL_TOP: begin
						if (ut_q == TOP_RESET) begin
							st = ST_UNDERFLOW;
						end else begin
							take_read = 1'b1;
							raddr     = ut_q;
							ut_d      = ut_q + 1'b1;
						end
					end
					default: begin
						if (mt1_q == mb_q) begin
							st = ST_UNDERFLOW;
						end else begin
							take_read = 1'b1;
							raddr     = mt1_q - 1'b1;
							mt1_d     = mt1_q - 1'b1;
						end
					end
				endcase
			end
		end
	end

	// Per-cell command: the written cell loads, the middle stack's cells shift as one.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_op[i] = OP_HOLD;
			if (accept) begin
				if (wr_en && waddr == PW'(i)) begin
					cell_op[i] = OP_LOAD;
				end else if (slide_up && PW'(i) > mb_q && PW'(i) <= mt1_q) begin
					cell_op[i] = OP_LEFT;
				end else if (slide_down && PW'(i + 1) >= mb_q && PW'(i + 1) < mt1_q) begin
					cell_op[i] = OP_RIGHT;
				end
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			word_t left_w, right_w;
			if (g == 0) begin : g_first
				assign left_w = '0;
			end else begin : g_left
				assign left_w = cell_word[g-1];
			end
			if (g == DEPTH - 1) begin : g_last
				assign right_w = '0;
			end else begin : g_right
				assign right_w = cell_word[g+1];
			end
			tsm_cell u_cell (
				.clk        (clk),
				.op         (cell_op[g]),
				.load_word  (req.push_value),
				.left_word  (left_w),
				.right_word (right_w),
				.word       (cell_word[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bt1_q       <= '0;
			mb_q        <= MID_RESET;
			mt1_q       <= MID_RESET;
			ut_q        <= TOP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				bt1_q <= bt1_d;
				mb_q  <= mb_d;
				mt1_q <= mt1_d;
				ut_q  <= ut_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The result word is chosen from the cells before this edge's shift or write.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= st;
			if (take_read) begin
				pop_value_q <= cell_word[raddr[IW-1:0]];
			end else if (st == ST_UNDERFLOW) begin
				pop_value_q <= MOST_NEG;
			end else begin
				pop_value_q <= '0;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.pop_value = pop_value_q;
	assign rsp.status    = status_q;

	// The four pointers always stay in order within the store.
	a_ptr_order: assert property (@(posedge clk) disable iff (!arst_n)
		bt1_q <= mb_q && mb_q <= mt1_q && mt1_q <= ut_q && ut_q <= TOP_RESET)
		else $error("stack pointers out of order");

	// A push into a store with no free word is refused as overflow.
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.mode == MODE_PUSH && req.stack_select != SEL_NONE && full
		|=> status_q == ST_OVERFLOW)
		else $error("push into a full store not reported as overflow");

	// A shift of the middle stack only happens on an accepted push.
	a_slide_push: assert property (@(posedge clk) disable iff (!arst_n)
		(slide_up || slide_down) && accept |-> req.mode == MODE_PUSH && !full)
		else $error("middle stack shifted outside a push");

	// A held result stays put until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |=> out_valid_q && $stable(pop_value_q) && $stable(status_q))
		else $error("stalled result changed");

endmodule

FILE: dv/tb_three_stacks_shared_memory_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for three_stacks_shared_memory_core: directed table, then biased random.
// Depends on tsm_pkg, tsm_if and the core; a local model of the three stacks predicts every result but the fixed rows'.
module tb_three_stacks_shared_memory_core;
	import tsm_pkg::*;

	localparam int DEPTH        = 16;
	localparam int RANDOM_ITEMS = 900;
	// Cycles with neither a request nor a result moving before the run is abandoned.
	localparam int IDLE_LIMIT   = 1000;
	localparam int REPORT_MAX   = 10;

	typedef struct {
		word_t   pop_value;
		status_t status;
	} result_t;

	// One row of the directed table. Rows marked fixed carry their result typed in;
	// the rest are checked against the local model. Pushes repeated over several
	// requests add the repeat index to the value so that every stored word differs.
	typedef struct {
		logic       mode;
		logic [1:0] sel;
		word_t      value;
		int         reps;
		bit         fixed;
		word_t      fixed_value;
		status_t    fixed_status;
	} directed_row_t;

	// Receiver behaviour, chosen afresh at random for each stretch of the run.
	typedef enum {STALL_NONE, STALL_PERIODIC, STALL_RANDOM, STALL_LONG} stall_style_t;

	logic clk;
	logic arst_n;

	tsm_req_if req_ch ();
	tsm_rsp_if rsp_ch ();

	three_stacks_shared_memory_core #(
		.DEPTH(DEPTH)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Local copy of the shared store and of the four stack pointers. The bottom stack
	// occupies 0..lo_sp, the top stack hi_sp..DEPTH-1 and the middle stack
	// mid_base..mid_sp, which is empty when mid_sp is one below mid_base.
	word_t stack_words [DEPTH];
	int    lo_sp;
	int    hi_sp;
	int    mid_base;
	int    mid_sp;

	result_t pending_results [$];

	// Handed from the driver to the request monitor along with each request.
	bit      drive_fixed;
	result_t drive_fixed_res;

	int accepted_reqs;
	int results_seen;
	int errors;
	int idle_cycles;
	int n_push;
	int n_pop;
	int n_overflow;
	int n_underflow;
	int n_slide;

	directed_row_t directed_rows [20] = '{
		// Every stack is empty straight after reset.
		'{MODE_POP,  SEL_BOTTOM, '0, 1, 1'b1, MOST_NEG, ST_UNDERFLOW},
		'{MODE_POP,  SEL_TOP,    '0, 1, 1'b1, MOST_NEG, ST_UNDERFLOW},
		'{MODE_POP,  SEL_MIDDLE, '0, 1, 1'b1, MOST_NEG, ST_UNDERFLOW},
		// With no stack selected nothing moves, whatever the mode.
		'{MODE_PUSH, SEL_NONE,   32'sh1234_5678, 1, 1'b1, '0, ST_OK},
		'{MODE_POP,  SEL_NONE,   '0, 1, 1'b1, '0, ST_OK},
		// Extreme words in and straight back out of each stack.
		'{MODE_PUSH, SEL_BOTTOM, 32'sh7FFF_FFFF, 1, 1'b1, '0, ST_OK},
		'{MODE_PUSH, SEL_TOP,    32'sh8000_0000, 1, 1'b1, '0, ST_OK},
		'{MODE_PUSH, SEL_MIDDLE, 32'shFFFF_FFFF, 1, 1'b1, '0, ST_OK},
		'{MODE_POP,  SEL_BOTTOM, '0, 1, 1'b1, 32'sh7FFF_FFFF, ST_OK},
		'{MODE_POP,  SEL_TOP,    '0, 1, 1'b1, 32'sh8000_0000, ST_OK},
		'{MODE_POP,  SEL_MIDDLE, '0, 1, 1'b1, 32'shFFFF_FFFF, ST_OK},
		// Fill the whole store: the bottom stack runs into the empty middle stack and
		// pushes it up, then the top and middle stacks take the remaining words.
		'{MODE_PUSH, SEL_BOTTOM, 32'shA5A5_0000, 7, 1'b0, '0, ST_OK},
		'{MODE_PUSH, SEL_TOP,    32'sh5A5A_0000, 4, 1'b0, '0, ST_OK},
		'{MODE_PUSH, SEL_MIDDLE, 32'sh0F0F_0000, 5, 1'b0, '0, ST_OK},
		// No free slot anywhere, so every push is refused.
		'{MODE_PUSH, SEL_MIDDLE, 32'sh0000_0001, 1, 1'b1, '0, ST_OVERFLOW},
		'{MODE_PUSH, SEL_BOTTOM, 32'sh0000_0002, 1, 1'b1, '0, ST_OVERFLOW},
		'{MODE_PUSH, SEL_TOP,    32'sh0000_0003, 1, 1'b1, '0, ST_OVERFLOW},
		// Free two slots at the bottom; the top and middle pushes then have to slide
		// the full middle stack down by one place each.
		'{MODE_POP,  SEL_BOTTOM, '0, 2, 1'b0, '0, ST_OK},
		'{MODE_PUSH, SEL_TOP,    32'shC3C3_C3C3, 1, 1'b0, '0, ST_OK},
		'{MODE_PUSH, SEL_MIDDLE, 32'sh3C3C_3C3C, 1, 1'b0, '0, ST_OK}
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Moves the middle stack one place towards the bottom stack.
	function automatic void slide_middle_down();
		for (int i = mid_base - 1; i < mid_sp; i++)
			stack_words[i] = stack_words[i + 1];
		mid_base--;
		mid_sp--;
		n_slide++;
	endfunction

	// Applies one request to the local store and returns the result it must give.
	function automatic result_t predict_access(logic m, logic [1:0] sel, word_t v);
		result_t r;
		bit      full;
		r.pop_value = '0;
		r.status    = ST_OK;
		full = (lo_sp == mid_base - 1) && (mid_sp + 1 == hi_sp);
		if (sel == SEL_NONE)
			return r;
		if (m == MODE_PUSH) begin
			if (full) begin
				r.status = ST_OVERFLOW;
			end else begin
				case (sel)
					SEL_BOTTOM: begin
						// The middle stack is in the way: shift it up by one place.
						if (lo_sp == mid_base - 1) begin
							for (int i = mid_sp + 1; i > mid_base; i--)
								stack_words[i] = stack_words[i - 1];
							mid_base++;
							mid_sp++;
							n_slide++;
						end
						lo_sp++;
						stack_words[lo_sp] = v;
					end
					SEL_TOP: begin
						if (hi_sp == mid_sp + 1)
							slide_middle_down();
						hi_sp--;
						stack_words[hi_sp] = v;
					end
					default: begin
						if (mid_sp == hi_sp - 1)
							slide_middle_down();
						mid_sp++;
						stack_words[mid_sp] = v;
					end
				endcase
			end
		end else begin
			case (sel)
				SEL_BOTTOM: begin
					if (lo_sp == -1) begin
						r.pop_value = MOST_NEG;
						r.status    = ST_UNDERFLOW;
					end else begin
						r.pop_value = stack_words[lo_sp];
						lo_sp--;
					end
				end
				SEL_TOP: begin
					if (hi_sp == DEPTH) begin
						r.pop_value = MOST_NEG;
						r.status    = ST_UNDERFLOW;
					end else begin
						r.pop_value = stack_words[hi_sp];
						hi_sp++;
					end
				end
				default: begin
					if (mid_sp == mid_base - 1) begin
						r.pop_value = MOST_NEG;
						r.status    = ST_UNDERFLOW;
					end else begin
						r.pop_value = stack_words[mid_sp];
						mid_sp--;
					end
				end
			endcase
		end
		return r;
	endfunction

	task automatic note_mismatch(string what, word_t want_v, word_t got_v);
		errors++;
		if (errors <= REPORT_MAX)
			$display("%0t ns: %s mismatch on result %0d: expected %h, got %h",
				$time, what, results_seen, want_v, got_v);
	endtask

	// Offers one request at a falling edge and returns at the first falling edge
	// after it has been taken. The caller may offer the next request at that edge.
	task automatic send_request(logic m, logic [1:0] s, word_t v, bit fixed, result_t fixed_res);
		int seen;
		seen = accepted_reqs;
		drive_fixed     = fixed;
		drive_fixed_res = fixed_res;
		req_ch.valid        <= 1'b1;
		req_ch.mode         <= m;
		req_ch.stack_select <= s;
		req_ch.push_value   <= v;
		do @(negedge clk); while (accepted_reqs == seen);
	endtask

	// Request and result monitor. It runs at the rising edge and so sees the values
	// that were settled before the edge: requests are predicted as they are taken,
	// results are checked in order against the oldest prediction still waiting.
	// The watchdog lives here too, since this is where progress is seen.
	always @(posedge clk) begin : monitor
		result_t want;
		bit      moved;
		moved = 1'b0;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				want = predict_access(req_ch.mode, req_ch.stack_select, req_ch.push_value);
				if (drive_fixed)
					want = drive_fixed_res;
				pending_results.push_back(want);
				if (req_ch.mode == MODE_PUSH)
					n_push++;
				else
					n_pop++;
				if (want.status == ST_OVERFLOW)
					n_overflow++;
				if (want.status == ST_UNDERFLOW)
					n_underflow++;
				accepted_reqs++;
				moved = 1'b1;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				moved = 1'b1;
				if (pending_results.size() == 0) begin
					note_mismatch("unrequested result, pop_value", '0, rsp_ch.pop_value);
				end else begin
					want = pending_results.pop_front();
					if (rsp_ch.pop_value !== want.pop_value)
						note_mismatch("pop_value", want.pop_value, rsp_ch.pop_value);
					if (rsp_ch.status !== want.status)
						note_mismatch("status", word_t'(want.status),
							word_t'(rsp_ch.status));
				end
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles, %0d results still awaited",
				$time, IDLE_LIMIT, pending_results.size());
			$display("tb_three_stacks_shared_memory_core: done, errors");
			$finish;
		end
	end

	// Result side back-pressure: long stretches of open flow alternate with a regular
	// one-in-four stall, scattered random stalls and occasional long holds.
	initial begin : result_sink
		stall_style_t style;
		int           left;
		int           hold;
		int           cyc;
		style = STALL_NONE;
		left  = 0;
		hold  = 0;
		cyc   = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				style = stall_style_t'($urandom_range(0, 3));
				left  = $urandom_range(40, 160);
			end
			left--;
			cyc++;
			case (style)
				STALL_NONE:     rsp_ch.ready <= 1'b1;
				STALL_PERIODIC: rsp_ch.ready <= (cyc % 4 != 3);
				STALL_RANDOM:   rsp_ch.ready <= ($urandom_range(0, 99) >= 35);
				default: begin
					if (hold > 0) begin
						hold--;
						rsp_ch.ready <= 1'b0;
					end else if ($urandom_range(0, 7) == 0) begin
						hold = $urandom_range(1, 11);
						rsp_ch.ready <= 1'b0;
					end else begin
						rsp_ch.ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// Request side: reset, the directed table, then random requests in bursts.
	initial begin : request_source
		result_t    no_fixed;
		logic       m;
		logic [1:0] s;
		word_t      v;
		int         sent;
		int         burst;
		int         gap;
		int         push_pct;
		int         focus;

		req_ch.valid        = 1'b0;
		req_ch.mode         = MODE_PUSH;
		req_ch.stack_select = SEL_NONE;
		req_ch.push_value   = '0;
		drive_fixed         = 1'b0;
		no_fixed.pop_value  = '0;
		no_fixed.status     = ST_OK;
		drive_fixed_res     = no_fixed;
		accepted_reqs = 0;
		results_seen  = 0;
		errors        = 0;
		idle_cycles   = 0;
		n_push        = 0;
		n_pop         = 0;
		n_overflow    = 0;
		n_underflow   = 0;
		n_slide       = 0;

		// The pointers come out of reset in their fixed places; the stored words
		// are simply zeroed, as no word is read before it has been written.
		foreach (stack_words[i])
			stack_words[i] = '0;
		lo_sp    = -1;
		hi_sp    = DEPTH;
		mid_sp   = (DEPTH - 1) / 3;
		mid_base = mid_sp + 1;

		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[r]) begin
			for (int k = 0; k < directed_rows[r].reps; k++)
				send_request(directed_rows[r].mode, directed_rows[r].sel,
					directed_rows[r].value + k, directed_rows[r].fixed,
					'{directed_rows[r].fixed_value, directed_rows[r].fixed_status});
		end

		// Random part. Every forty requests the mix swings between mostly pushes,
		// mostly pops and an even split, so the store keeps filling to overflow and
		// draining to underflow; half of those phases lean on one stack so that it
		// collides with its neighbours and drives the middle stack both ways.
		sent     = 0;
		push_pct = 50;
		focus    = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 24);
			for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				if (sent % 40 == 0) begin
					case ($urandom_range(0, 2))
						0:       push_pct = 85;
						1:       push_pct = 15;
						default: push_pct = 50;
					endcase
					focus = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
				end
				m = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
				if ($urandom_range(0, 99) < 3)
					s = SEL_NONE;
				else if (focus != 0 && $urandom_range(0, 99) < 70)
					s = focus[1:0];
				else
					s = 2'($urandom_range(1, 3));
				case ($urandom_range(0, 15))
					0:       v = MOST_NEG;
					1:       v = ~MOST_NEG;
					2:       v = '0;
					3:       v = '1;
					default: v = word_t'($urandom);
				endcase
				send_request(m, s, v, 1'b0, no_fixed);
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end

		// Drain: wait for every outstanding result, then keep the clock running idle so that a
		// stray extra result would still be caught by the monitor.
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Covered %0d requests (%0d pushes, %0d pops) and checked %0d results.",
			accepted_reqs, n_push, n_pop, results_seen);
		$display("Saw %0d overflows, %0d underflows and %0d middle-stack slides; %0d mismatches.",
			n_overflow, n_underflow, n_slide, errors);
		if (errors == 0)
			$display("tb_three_stacks_shared_memory_core: done, clean");
		else
			$display("tb_three_stacks_shared_memory_core: done, errors");
		$finish;
	end

endmodule
